// ===== rtl/pal_pkg.sv =====
// shared types and constants for the pi position actuator loop
`default_nettype none

package pal_pkg;

	localparam int PWM_LIMIT = 400;
	localparam int DEADBAND  = 2;

	// integral divisor: 16 for the q4.4 gain times 1000 for milliseconds
	localparam int INTEG_SCALE = 16000;

	// divide by 16000 as a shift by 7, then times ceil(2^22 / 125) and a shift by 22
	// exact for every magnitude below the clamp level
	localparam int INTEG_PRESHIFT = 7;
	localparam int INTEG_RECIP    = 33555;
	localparam int INTEG_SHIFT    = 22;
	localparam int INTEG_SAT      = (PWM_LIMIT + 1) * INTEG_SCALE;

	localparam int DIV_NUM_W = 18;
	localparam int DIV_DEN_W = 14;
	localparam int DIV_CNT_W = 6;
	localparam int MAP_STEPS = 18;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 10;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROP_GAIN     = 4'd0,
		REG_INTEG_GAIN    = 4'd1,
		REG_ADC_LOW       = 4'd2,
		REG_ADC_HIGH      = 4'd3,
		REG_ANGLE_LOW     = 4'd4,
		REG_ANGLE_HIGH    = 4'd5,
		REG_FAULT_FLOOR   = 4'd6,
		REG_FAULT_CEILING = 4'd7
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] prop_gain;
		logic [7:0] integ_gain;
		logic [9:0] adc_low_point;
		logic [9:0] adc_high_point;
		logic [7:0] angle_at_low_point;
		logic [7:0] angle_at_high_point;
		logic [9:0] fault_floor;
		logic [9:0] fault_ceiling;
	} cfg_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
		logic [DIV_CNT_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_NUM_W-1:0] quo;
	} div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/pal_cfg.sv =====
// configuration register file
`default_nettype none

module pal_cfg import pal_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain           <= 8'd24;
			cfg_q.integ_gain          <= 8'd48;
			cfg_q.adc_low_point       <= 10'd365;
			cfg_q.adc_high_point      <= 10'd796;
			cfg_q.angle_at_low_point  <= 8'hd9;
			cfg_q.angle_at_high_point <= 8'd55;
			cfg_q.fault_floor         <= 10'd0;
			cfg_q.fault_ceiling       <= 10'd1023;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_PROP_GAIN:     cfg_q.prop_gain           <= cfg_data[7:0];
				REG_INTEG_GAIN:    cfg_q.integ_gain          <= cfg_data[7:0];
				REG_ADC_LOW:       cfg_q.adc_low_point       <= cfg_data;
				REG_ADC_HIGH:      cfg_q.adc_high_point      <= cfg_data;
				REG_ANGLE_LOW:     cfg_q.angle_at_low_point  <= cfg_data[7:0];
				REG_ANGLE_HIGH:    cfg_q.angle_at_high_point <= cfg_data[7:0];
				REG_FAULT_FLOOR:   cfg_q.fault_floor         <= cfg_data;
				REG_FAULT_CEILING: cfg_q.fault_ceiling       <= cfg_data;
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/pal_div.sv =====
// unsigned restoring divider, one quotient bit per cycle
`default_nettype none

module pal_div import pal_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  div_req_t  req,
	output div_rsp_t  rsp
);

	logic [DIV_NUM_W-1:0] num_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 run_q;
	logic                 done_q;

	logic [DIV_DEN_W:0] trial;
	logic [DIV_DEN_W:0] diff;
	logic               fits;

	assign trial = {rem_q, num_q[DIV_NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= req.steps;
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_W'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (run_q) begin
			rem_q <= fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
			num_q <= {num_q[DIV_NUM_W-2:0], 1'b0};
			quo_q <= {quo_q[DIV_NUM_W-2:0], fits};
		end
	end

endmodule

`default_nettype wire

// ===== rtl/pi_position_actuator_loop.sv =====
// pi position actuator loop: sequencer, shared multiplier and output register
//
// Usage:
//   Input channel (in_valid/in_ready) takes target_angle, sensor_sample and
//   elapsed_ms. Result channel (out_valid/out_ready) gives drive_level,
//   angle_error and sensor_fault, exactly one result per input transfer.
//   Config channel (cfg_valid/cfg_ready) writes register cfg_index with
//   cfg_data; it is always ready, and the user must write it only while the loop
//   is idle, which the block itself does not enforce.
// Sequence:
//   A faulted sample gives its result once the output register is free. A
//   normal item is scaled on the shared multiplier, divided on the serial
//   divider for the calibration, then takes its integral terms, integral
//   scaling included, and proportional term on the shared multiplier. With
//   equal calibration points the division is skipped; inputs are taken in idle.
// Reset and stall:
//   arst_n restores the register defaults and clears the integral term.
//   The result sits in an output register, so the next input is accepted
//   while it waits; a finished item stalls only if that register is full.
`default_nettype none

module pi_position_actuator_loop import pal_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic signed [7:0]     target_angle,
	input  wire logic [9:0]            sensor_sample,
	input  wire logic [15:0]           elapsed_ms,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic signed [9:0]          drive_level,
	output logic signed [10:0]         angle_error,
	output logic                       sensor_fault,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [12:0] {
		S_IDLE   = 13'b0000000000001,
		S_CHECK  = 13'b0000000000010,
		S_MAPMUL = 13'b0000000000100,
		S_MAPST  = 13'b0000000001000,
		S_MAPWT  = 13'b0000000010000,
		S_ANGLE  = 13'b0000000100000,
		S_MUL1   = 13'b0000001000000,
		S_MUL2   = 13'b0000010000000,
		S_MUL3   = 13'b0000100000000,
		S_IST    = 13'b0001000000000,
		S_INTEG  = 13'b0010000000000,
		S_PROP   = 13'b0100000000000,
		S_FIN    = 13'b1000000000000
	} state_t;

	localparam logic signed [36:0] P_LIM = 37'(PWM_LIMIT);
	localparam logic signed [10:0] D_BAND = 11'(DEADBAND);

	cfg_t     cfg;
	div_req_t div_req;
	div_rsp_t div_rsp;

	state_t state_q;

	logic signed [7:0]  target_q;
	logic [9:0]         sample_q;
	logic [15:0]        ms_q;
	logic signed [36:0] p_q;
	logic signed [36:0] sum_q;
	logic signed [10:0] err_q;
	logic signed [9:0]  integ_q;
	logic               neg_q;
	logic               big_q;
	logic               map_zero_q;

	logic               out_valid_q;
	logic signed [9:0]  drive_q;
	logic signed [10:0] err_out_q;
	logic               fault_q;

	logic               can_load;
	logic               fault;
	logic signed [10:0] samp_diff;
	logic signed [8:0]  span;
	logic signed [10:0] cal_den;
	logic [10:0]        den_abs;
	logic [36:0]        p_abs;
	logic [36:0]        sum_abs;

	logic signed [19:0] mul_a;
	logic signed [16:0] mul_b;
	logic signed [36:0] mul_p;

	logic signed [18:0] map_q;
	logic signed [19:0] angle;
	logic signed [20:0] err_diff;
	logic signed [10:0] err_next;
	logic [9:0]         lim_mag;
	logic signed [9:0]  integ_next;
	logic signed [36:0] pi_full;
	logic signed [9:0]  pi_sat;
	logic signed [9:0]  drive_next;

	pal_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pal_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign in_ready     = (state_q == S_IDLE);
	assign out_valid    = out_valid_q;
	assign drive_level  = drive_q;
	assign angle_error  = err_out_q;
	assign sensor_fault = fault_q;
	assign can_load     = !out_valid_q || out_ready;

	// calibration terms
	assign fault     = (sample_q < cfg.fault_floor) || (sample_q > cfg.fault_ceiling);
	assign samp_diff = $signed({1'b0, sample_q}) - $signed({1'b0, cfg.adc_low_point});
	assign span      = 9'($signed(cfg.angle_at_high_point))
		- 9'($signed(cfg.angle_at_low_point));
	assign cal_den   = $signed({1'b0, cfg.adc_high_point})
		- $signed({1'b0, cfg.adc_low_point});
	assign den_abs   = cal_den[10] ? 11'(-cal_den) : 11'(cal_den);
	assign p_abs     = p_q[36] ? 37'(-p_q) : 37'(p_q);
	assign sum_abs   = sum_q[36] ? 37'(-sum_q) : 37'(sum_q);

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_MAPMUL: begin
				mul_a = 20'(samp_diff);
				mul_b = 17'(span);
			end
			S_MUL1: begin
				mul_a = 20'(err_q);
				mul_b = $signed({9'd0, cfg.integ_gain});
			end
			S_MUL2: begin
				mul_a = $signed(p_q[19:0]);
				mul_b = $signed({1'b0, ms_q});
			end
			S_MUL3: begin
				mul_a = 20'(integ_q);
				mul_b = 17'(INTEG_SCALE);
			end
			S_IST: begin
				mul_a = $signed({4'd0, sum_abs[INTEG_PRESHIFT+15:INTEG_PRESHIFT]});
				mul_b = 17'(INTEG_RECIP);
			end
			S_PROP: begin
				mul_a = 20'(err_q);
				mul_b = $signed({9'd0, cfg.prop_gain});
			end
			default: begin
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// divider requests
	always_comb begin
		div_req.start = 1'b0;
		div_req.num   = '0;
		div_req.den   = '0;
		div_req.steps = '0;
		unique case (state_q)
			S_MAPST: begin
				div_req.start = 1'b1;
				div_req.num   = p_abs[DIV_NUM_W-1:0];
				div_req.den   = DIV_DEN_W'(den_abs);
				div_req.steps = DIV_CNT_W'(MAP_STEPS);
			end
			default: begin
			end
		endcase
	end

	// angle and saturated error
	always_comb begin
		if (map_zero_q) begin
			map_q = '0;
		end else if (neg_q) begin
			map_q = -$signed({1'b0, div_rsp.quo[17:0]});
		end else begin
			map_q = $signed({1'b0, div_rsp.quo[17:0]});
		end
		angle    = 20'($signed(cfg.angle_at_low_point)) + 20'(map_q);
		err_diff = 21'(target_q) - 21'(angle);
		if (err_diff < -21'sd1024) begin
			err_next = -11'sd1024;
		end else if (err_diff > 21'sd1023) begin
			err_next = 11'sd1023;
		end else begin
			err_next = err_diff[10:0];
		end
	end

	// integral clamp on the quotient magnitude
	always_comb begin
		if (big_q) begin
			lim_mag = 10'(PWM_LIMIT);
		end else begin
			lim_mag = p_q[INTEG_SHIFT+9:INTEG_SHIFT];
		end
		integ_next = neg_q ? -$signed(lim_mag) : $signed(lim_mag);
	end

	// p plus i, truncated toward zero, clamped, negated, deadband
	always_comb begin
		pi_full = (p_q + (p_q[36] ? 37'sd15 : 37'sd0)) >>> 4;
		if (pi_full > P_LIM) begin
			pi_sat = 10'(PWM_LIMIT);
		end else if (pi_full < -P_LIM) begin
			pi_sat = -10'(PWM_LIMIT);
		end else begin
			pi_sat = pi_full[9:0];
		end
		if ((err_q > -D_BAND) && (err_q < D_BAND)) begin
			drive_next = '0;
		end else begin
			drive_next = -pi_sat;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			integ_q     <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (fault) begin
						if (can_load) begin
							out_valid_q <= 1'b1;
							state_q     <= S_IDLE;
						end
					end else if (cal_den == '0) begin
						state_q <= S_ANGLE;
					end else begin
						state_q <= S_MAPMUL;
					end
				end
				S_MAPMUL: state_q <= S_MAPST;
				S_MAPST:  state_q <= S_MAPWT;
				S_MAPWT: begin
					if (div_rsp.done) begin
						state_q <= S_ANGLE;
					end
				end
				S_ANGLE: state_q <= S_MUL1;
				S_MUL1:  state_q <= S_MUL2;
				S_MUL2:  state_q <= S_MUL3;
				S_MUL3:  state_q <= S_IST;
				S_IST:   state_q <= S_INTEG;
				S_INTEG: begin
					integ_q <= integ_next;
					state_q <= S_PROP;
				end
				S_PROP: state_q <= S_FIN;
				S_FIN: begin
					if (can_load) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					target_q <= target_angle;
					sample_q <= sensor_sample;
					ms_q     <= elapsed_ms;
				end
			end
			S_CHECK: begin
				map_zero_q <= (cal_den == '0);
				if (fault && can_load) begin
					drive_q   <= '0;
					err_out_q <= '0;
					fault_q   <= 1'b1;
				end
			end
			S_MAPMUL: p_q <= mul_p;
			S_MAPST:  neg_q <= p_q[36] ^ cal_den[10];
			S_ANGLE:  err_q <= err_next;
			S_MUL1:   p_q <= mul_p;
			S_MUL2:   p_q <= mul_p;
			S_MUL3:   sum_q <= p_q + mul_p;
			S_IST: begin
				neg_q <= sum_q[36];
				big_q <= (sum_abs >= 37'(INTEG_SAT));
				p_q   <= mul_p;
			end
			S_PROP:   p_q <= mul_p + (37'(integ_q) <<< 4);
			S_FIN: begin
				if (can_load) begin
					drive_q   <= drive_next;
					err_out_q <= err_q;
					fault_q   <= 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire
